/* rtl/dslw_pkg.sv */
// ----------------------------------------------------------------------------
// dslw_pkg
// Shared types and constants of the daily schedule light switch.
// ----------------------------------------------------------------------------
`default_nettype none

package dslw_pkg;

  // Number of schedule entries and the address width of the table
  localparam int unsigned NUM_ENTRIES = 20;
  localparam int unsigned ENTRY_AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_WRITE   = 3'd1,
    FUNC_ON      = 3'd2,
    FUNC_OFF     = 3'd3,
    FUNC_TOGGLE  = 3'd4,
    FUNC_SET     = 3'd5,
    FUNC_PREVIEW = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    MODE_ON_EN   = 2'd0,
    MODE_OFF_EN  = 2'd1,
    MODE_ON_DIS  = 2'd2,
    MODE_OFF_DIS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_FIRED   = 2'd1,
    CAUSE_COMMAND = 2'd2,
    CAUSE_TABLE   = 2'd3
  } cause_e;

  // One schedule entry as held in the table memory
  typedef struct packed {
    logic [6:0] hour;
    logic [6:0] minute;
    mode_e      mode;
    logic [7:0] bright;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/dslw_ram.sv */
// ----------------------------------------------------------------------------
// dslw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dslw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/daily_schedule_light_switch.sv */
// ----------------------------------------------------------------------------
// daily_schedule_light_switch
// Daily schedule table, light state, brightness and PWM drive level.
// ----------------------------------------------------------------------------
// Every transfer on the input channel returns exactly one result. Commands
// (on, off, toggle, set brightness, preview) and table writes have their
// result offered on the cycle after the input transfer, and a new item can
// follow at once unless that result waits under stall. A tick walks the
// schedule table through the single read port of the table memory, one entry
// per cycle; its result is offered once the last entry has been checked, and
// no new item is taken while the walk runs.
// The table resets to all entries disabled through one valid flag per entry;
// no clearing pass is needed after reset. The input is held off while a
// result waits under stall; an item is taken on the edge at which the earlier
// result leaves, or once the result register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module daily_schedule_light_switch (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] func_i,
  input  wire logic [4:0] now_hour_i,
  input  wire logic [5:0] now_minute_i,
  input  wire logic [5:0] now_second_i,
  input  wire logic [6:0] entry_index_i,
  input  wire logic [6:0] entry_hour_i,
  input  wire logic [6:0] entry_minute_i,
  input  wire logic [1:0] entry_mode_i,
  input  wire logic [7:0] level_value_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            light_on_o,
  output logic [6:0]      brightness_pct_o,
  output logic [7:0]      pwm_level_o,
  output logic [1:0]      cause_o
);

  localparam int unsigned AW = dslw_pkg::ENTRY_AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(dslw_pkg::NUM_ENTRIES - 1);
  // floor(x / 100) = (x * 5243) >> 19 for every x up to 100 * 255
  localparam logic [12:0] PWM_RECIP = 13'd5243;

  // An entry that was never written reads as hour out of range, disabled
  localparam dslw_pkg::entry_t ENTRY_RESET = '{
    hour:   7'h7F,
    minute: 7'd0,
    mode:   dslw_pkg::MODE_OFF_DIS,
    bright: 8'd0
  };

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Percent (0 to 100) to drive level, truncated
  function automatic logic [7:0] pct_to_pwm(input logic [6:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = (15'(pct) << 8) - 15'(pct);
    prod   = 28'(scaled) * 28'(PWM_RECIP);
    return prod[26:19];
  endfunction

  function automatic logic [6:0] clip_pct(input logic [7:0] value);
    return (value > 8'd100) ? 7'd0 : value[6:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic                  lock_q, lock_d;
  logic                  light_q, light_d;
  logic [6:0]            level_q, level_d;
  logic                  prev_hold_q, prev_hold_d;
  logic [6:0]            prev_level_q, prev_level_d;
  logic [dslw_pkg::NUM_ENTRIES-1:0] entry_vld_q, entry_vld_d;

  // scan sequencer
  logic [AW-1:0]         scan_addr_q, scan_addr_d;
  logic                  issue_q, issue_d;
  logic                  chk_q, chk_d;
  logic [AW-1:0]         chk_addr_q, chk_addr_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  fired_q, fired_d;
  logic [4:0]            hour_q, hour_d;
  logic [5:0]            minute_q, minute_d;
  logic [5:0]            second_q, second_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic                  out_light_q, out_light_d;
  logic [6:0]            out_level_q, out_level_d;
  logic [7:0]            out_pwm_q, out_pwm_d;
  dslw_pkg::cause_e      out_cause_q, out_cause_d;

  // table memory access
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  dslw_pkg::entry_t      ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  dslw_pkg::entry_t      ram_rdata;

  logic                  in_accept;
  logic                  load_out;
  dslw_pkg::cause_e      cause_n;
  dslw_pkg::entry_t      chk_entry;
  logic [6:0]            fire_level;
  logic [6:0]            pct_n;

  dslw_ram #(
    .WIDTH ($bits(dslw_pkg::entry_t)),
    .DEPTH (dslw_pkg::NUM_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take an item only when idle and the result register is free or freeing
  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Entry under check this cycle; an entry never written reads as reset
  assign chk_entry = rd_vld_q ? ram_rdata : ENTRY_RESET;

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    lock_d       = lock_q;
    light_d      = light_q;
    level_d      = level_q;
    prev_hold_d  = prev_hold_q;
    prev_level_d = prev_level_q;
    entry_vld_d  = entry_vld_q;
    scan_addr_d  = scan_addr_q;
    issue_d      = issue_q;
    chk_d        = 1'b0;
    chk_addr_d   = chk_addr_q;
    rd_vld_d     = rd_vld_q;
    fired_d      = fired_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_addr_q;
    ram_wdata    = chk_entry;
    ram_re       = 1'b0;
    ram_raddr    = scan_addr_q;
    load_out     = 1'b0;
    cause_n      = dslw_pkg::CAUSE_NONE;
    fire_level   = clip_pct(chk_entry.bright);

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          load_out = 1'b1;
          case (dslw_pkg::func_e'(func_i))
            dslw_pkg::FUNC_TICK: begin
              // Latch the time and start the table walk; result comes at its end
              load_out    = 1'b0;
              hour_d      = now_hour_i;
              minute_d    = now_minute_i;
              second_d    = now_second_i;
              scan_addr_d = '0;
              issue_d     = 1'b1;
              fired_d     = 1'b0;
              state_d     = ST_SCAN;
            end
            dslw_pkg::FUNC_WRITE: begin
              if (entry_index_i < 7'(dslw_pkg::NUM_ENTRIES)) begin
                ram_we      = 1'b1;
                ram_waddr   = entry_index_i[AW-1:0];
                ram_wdata   = '{
                  hour:   entry_hour_i,
                  minute: entry_minute_i,
                  mode:   dslw_pkg::mode_e'(entry_mode_i),
                  bright: level_value_i
                };
                entry_vld_d[entry_index_i[AW-1:0]] = 1'b1;
                lock_d      = 1'b1;
                prev_hold_d = 1'b0;
                cause_n     = dslw_pkg::CAUSE_TABLE;
              end
            end
            dslw_pkg::FUNC_ON: begin
              light_d = 1'b1;
              cause_n = dslw_pkg::CAUSE_COMMAND;
            end
            dslw_pkg::FUNC_OFF: begin
              light_d = 1'b0;
              level_d = 7'd0;
              cause_n = dslw_pkg::CAUSE_COMMAND;
            end
            dslw_pkg::FUNC_TOGGLE: begin
              light_d = !light_q;
              cause_n = dslw_pkg::CAUSE_COMMAND;
            end
            dslw_pkg::FUNC_SET: begin
              level_d = clip_pct(level_value_i);
              cause_n = dslw_pkg::CAUSE_COMMAND;
            end
            dslw_pkg::FUNC_PREVIEW: begin
              prev_hold_d  = 1'b1;
              prev_level_d = clip_pct(level_value_i);
              cause_n      = dslw_pkg::CAUSE_COMMAND;
            end
            default: begin
              cause_n = dslw_pkg::CAUSE_NONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue stage: read one entry per cycle
        if (issue_q) begin
          ram_re     = 1'b1;
          chk_d      = 1'b1;
          chk_addr_d = scan_addr_q;
          rd_vld_d   = entry_vld_q[scan_addr_q];
          if (scan_addr_q == LAST_ADDR) begin
            issue_d = 1'b0;
          end else begin
            scan_addr_d = scan_addr_q + AW'(1);
          end
        end

        // Check stage: the write-back goes to the entry read in the previous
        // cycle, never to the one being read now
        if (chk_q) begin
          if ((chk_entry.hour < 7'd24) && (chk_entry.minute < 7'd60)) begin
            if ((chk_entry.hour == 7'(hour_q)) && (chk_entry.minute == 7'(minute_q)) &&
                (second_q inside {[6'd1:6'd10]}) &&
                (chk_entry.mode inside {dslw_pkg::MODE_ON_EN, dslw_pkg::MODE_OFF_EN}) &&
                !lock_q) begin
              lock_d  = 1'b1;
              level_d = fire_level;
              light_d = (chk_entry.mode == dslw_pkg::MODE_ON_EN);
              fired_d = 1'b1;
              if (chk_entry.bright > 8'd100) begin
                ram_we           = 1'b1;
                ram_waddr        = chk_addr_q;
                ram_wdata        = chk_entry;
                ram_wdata.bright = 8'd0;
              end
            end
            if (second_q >= 6'd11) begin
              lock_d = 1'b0;
            end
          end
          if (chk_addr_q == LAST_ADDR) begin
            state_d  = ST_IDLE;
            load_out = 1'b1;
            cause_n  = fired_d ? dslw_pkg::CAUSE_FIRED : dslw_pkg::CAUSE_NONE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result payload from the state as it stands after the item
  assign pct_n = prev_hold_d ? prev_level_d : level_d;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_light_d = out_light_q;
    out_level_d = out_level_q;
    out_pwm_d   = out_pwm_q;
    out_cause_d = out_cause_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_light_d = light_d;
      out_level_d = level_d;
      out_pwm_d   = light_d ? pct_to_pwm(pct_n) : 8'd0;
      out_cause_d = cause_n;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lock_q       <= 1'b0;
      light_q      <= 1'b0;
      level_q      <= 7'd0;
      prev_hold_q  <= 1'b0;
      prev_level_q <= 7'd0;
      entry_vld_q  <= '0;
      issue_q      <= 1'b0;
      chk_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lock_q       <= lock_d;
      light_q      <= light_d;
      level_q      <= level_d;
      prev_hold_q  <= prev_hold_d;
      prev_level_q <= prev_level_d;
      entry_vld_q  <= entry_vld_d;
      issue_q      <= issue_d;
      chk_q        <= chk_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    chk_addr_q  <= chk_addr_d;
    rd_vld_q    <= rd_vld_d;
    fired_q     <= fired_d;
    hour_q      <= hour_d;
    minute_q    <= minute_d;
    second_q    <= second_d;
    out_light_q <= out_light_d;
    out_level_q <= out_level_d;
    out_pwm_q   <= out_pwm_d;
    out_cause_q <= out_cause_d;
  end

  assign out_valid_o      = out_valid_q;
  assign light_on_o       = out_light_q;
  assign brightness_pct_o = out_level_q;
  assign pwm_level_o      = out_pwm_q;
  assign cause_o          = out_cause_q;

endmodule

`default_nettype wire

/* rtl/dslw_checker.sv */
// ----------------------------------------------------------------------------
// dslw_checker
// Port-level checks of the daily schedule light switch, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dslw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [2:0] func_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       light_on_o,
  input wire logic [6:0] brightness_pct_o,
  input wire logic [7:0] pwm_level_o,
  input wire logic [1:0] cause_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(light_on_o) && $stable(brightness_pct_o) &&
      $stable(pwm_level_o) && $stable(cause_o))
    else $error("stalled result changed");

  // Drive level is zero whenever the light is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !light_on_o |-> pwm_level_o == 8'd0)
    else $error("pwm non-zero while light off");

  // Stored brightness never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> brightness_pct_o <= 7'd100)
    else $error("brightness above 100");

  // An on command is answered on the next cycle with the light on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && func_i == dslw_pkg::FUNC_ON |=>
      out_valid_o && light_on_o && cause_o == dslw_pkg::CAUSE_COMMAND)
    else $error("on command not answered");

  // An off command is answered on the next cycle with light off, level zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && func_i == dslw_pkg::FUNC_OFF |=>
      out_valid_o && !light_on_o && brightness_pct_o == 7'd0)
    else $error("off command not answered");

endmodule

bind daily_schedule_light_switch dslw_checker u_dslw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .func_i           (func_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .light_on_o       (light_on_o),
  .brightness_pct_o (brightness_pct_o),
  .pwm_level_o      (pwm_level_o),
  .cause_o          (cause_o)
);

`default_nettype wire

/* tb/dslw_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dslw_result_checker
// Watches both channels of the schedule light switch and checks each result.
// ----------------------------------------------------------------------------
// Every input transfer is run through a behavioural copy of the switch. The
// copy holds the schedule table, the firing lock, the lamp and the preview.
// The expected lamp result joins a queue. Each result transfer is compared
// field by field with the oldest queued entry.
// ----------------------------------------------------------------------------

module dslw_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] func_i,
  input  logic [4:0] now_hour_i,
  input  logic [5:0] now_minute_i,
  input  logic [5:0] now_second_i,
  input  logic [6:0] entry_index_i,
  input  logic [6:0] entry_hour_i,
  input  logic [6:0] entry_minute_i,
  input  logic [1:0] entry_mode_i,
  input  logic [7:0] level_value_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       light_on_i,
  input  logic [6:0] brightness_pct_i,
  input  logic [7:0] pwm_level_i,
  input  logic [1:0] cause_i,
  output int         fail_count_o,
  output int         pending_count_o
);

  import dslw_pkg::*;

  typedef struct packed {
    logic       lit;
    logic [6:0] pct;
    logic [7:0] pwm;
    cause_e     cause;
  } lamp_result_t;

  // Behavioural copy of the switch state
  logic [7:0] slot_hour   [NUM_ENTRIES];
  logic [6:0] slot_minute [NUM_ENTRIES];
  mode_e      slot_mode   [NUM_ENTRIES];
  logic [7:0] slot_bright [NUM_ENTRIES];
  logic       fire_held;
  logic       lamp_lit;
  logic [6:0] lamp_pct;
  logic       pv_active;
  logic [6:0] pv_pct;

  lamp_result_t lamp_results_due [$];
  lamp_result_t due;
  lamp_result_t seen;
  int           fails;

  function automatic logic [6:0] clip_pct(input logic [7:0] v);
    return (v > 8'd100) ? 7'd0 : v[6:0];
  endfunction

  function automatic logic [7:0] pct_to_pwm(input logic [6:0] p);
    int unsigned scaled;
    scaled = (int'(p) * 255) / 100;
    return scaled[7:0];
  endfunction

  task automatic clear_switch();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      slot_hour[i]   = 8'd255;
      slot_minute[i] = 7'd0;
      slot_mode[i]   = MODE_OFF_DIS;
      slot_bright[i] = 8'd0;
    end
    fire_held = 1'b0;
    lamp_lit  = 1'b0;
    lamp_pct  = 7'd0;
    pv_active = 1'b0;
    pv_pct    = 7'd0;
  endtask

  task automatic predict_lamp_result(output lamp_result_t r);
    cause_e     why;
    logic [6:0] shown;
    why = CAUSE_NONE;
    case (func_i)
      FUNC_TICK: begin
        // Scan in index order; entries with an impossible time are skipped,
        // lock release included
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (slot_hour[i] < 8'd24 && slot_minute[i] < 7'd60) begin
            if (slot_hour[i] == {3'b000, now_hour_i} &&
                slot_minute[i] == {1'b0, now_minute_i} &&
                now_second_i >= 6'd1 && now_second_i <= 6'd10 &&
                (slot_mode[i] == MODE_ON_EN || slot_mode[i] == MODE_OFF_EN) &&
                !fire_held) begin
              fire_held = 1'b1;
              if (slot_bright[i] > 8'd100) slot_bright[i] = 8'd0;
              lamp_pct = slot_bright[i][6:0];
              lamp_lit = (slot_mode[i] == MODE_ON_EN);
              why      = CAUSE_FIRED;
            end
            if (now_second_i >= 6'd11) fire_held = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        if (entry_index_i < NUM_ENTRIES) begin
          slot_hour[entry_index_i]   = {1'b0, entry_hour_i};
          slot_minute[entry_index_i] = entry_minute_i;
          slot_mode[entry_index_i]   = mode_e'(entry_mode_i);
          slot_bright[entry_index_i] = level_value_i;
          fire_held = 1'b1;
          pv_active = 1'b0;
          why       = CAUSE_TABLE;
        end
      end
      FUNC_ON: begin
        lamp_lit = 1'b1;
        why      = CAUSE_COMMAND;
      end
      FUNC_OFF: begin
        lamp_lit = 1'b0;
        lamp_pct = 7'd0;
        why      = CAUSE_COMMAND;
      end
      FUNC_TOGGLE: begin
        lamp_lit = !lamp_lit;
        why      = CAUSE_COMMAND;
      end
      FUNC_SET: begin
        lamp_pct = clip_pct(level_value_i);
        why      = CAUSE_COMMAND;
      end
      FUNC_PREVIEW: begin
        pv_active = 1'b1;
        pv_pct    = clip_pct(level_value_i);
        why       = CAUSE_COMMAND;
      end
      default: ;
    endcase
    shown   = pv_active ? pv_pct : lamp_pct;
    r.lit   = lamp_lit;
    r.pct   = lamp_pct;
    r.pwm   = lamp_lit ? pct_to_pwm(shown) : 8'd0;
    r.cause = why;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_switch();
      lamp_results_due.delete();
      fails = 0;
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      // Retire first: a result never belongs to the item taken on this edge
      if (out_valid_i && !out_stall_i) begin
        seen = '{light_on_i, brightness_pct_i, pwm_level_i, cause_e'(cause_i)};
        if (lamp_results_due.size() == 0) begin
          $display("%0t: result with none outstanding, actual lit %0d pct %0d pwm %0d cause %0d",
                   $time, seen.lit, seen.pct, seen.pwm, seen.cause);
          fails++;
        end else begin
          due = lamp_results_due.pop_front();
          check_field("light_on", int'(due.lit), int'(seen.lit));
          check_field("brightness_pct", int'(due.pct), int'(seen.pct));
          check_field("pwm_level", int'(due.pwm), int'(seen.pwm));
          check_field("cause", int'(due.cause), int'(seen.cause));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_lamp_result(due);
        lamp_results_due.push_back(due);
      end
      fail_count_o    <= fails;
      pending_count_o <= lamp_results_due.size();
    end
  end

endmodule

/* tb/tb_daily_schedule_light_switch.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_daily_schedule_light_switch
// Stimulus and verdict for the daily schedule light switch.
// ----------------------------------------------------------------------------
// A directed opening walks the firing rules: lock, lock release, second zero,
// first-match order, disabled and impossible entries, out-of-range writes,
// brightness clipping, preview and every command. Random traffic follows,
// mostly table writes and ticks aimed at written times, so that the lock and
// firing paths are exercised hard. Both channels idle at random. Checking
// lives in dslw_result_checker; this module drives and gives the verdict.
// ----------------------------------------------------------------------------

module tb_daily_schedule_light_switch;

  import dslw_pkg::*;

  localparam logic [2:0] FUNC_UNUSED  = 3'd7;
  localparam int         RANDOM_ITEMS = 1650;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         DRAIN_CYCLES = 30;

  // One input item as placed on the channel
  typedef struct packed {
    logic [2:0] fn;
    logic [4:0] hh;
    logic [5:0] mm;
    logic [5:0] ss;
    logic [6:0] idx;
    logic [6:0] eh;
    logic [6:0] em;
    logic [1:0] emode;
    logic [7:0] lvl;
  } cmd_t;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic quiet    = 1'b0;
  cmd_t drv      = '0;

  logic       in_stall;
  logic       out_valid;
  logic       light_on;
  logic [6:0] brightness_pct;
  logic [7:0] pwm_level;
  logic [1:0] cause;
  int         fail_count;
  int         pending_count;

  // Times last written to each slot, so that ticks can be aimed at them
  logic [6:0] aim_hour   [NUM_ENTRIES];
  logic [6:0] aim_minute [NUM_ENTRIES];

  int stall_left;
  int stall_roll;
  int idle_cycles;

  always #2 clk = ~clk;

  daily_schedule_light_switch u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (drv.fn),
    .now_hour_i       (drv.hh),
    .now_minute_i     (drv.mm),
    .now_second_i     (drv.ss),
    .entry_index_i    (drv.idx),
    .entry_hour_i     (drv.eh),
    .entry_minute_i   (drv.em),
    .entry_mode_i     (drv.emode),
    .level_value_i    (drv.lvl),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .light_on_o       (light_on),
    .brightness_pct_o (brightness_pct),
    .pwm_level_o      (pwm_level),
    .cause_o          (cause)
  );

  dslw_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (drv.fn),
    .now_hour_i       (drv.hh),
    .now_minute_i     (drv.mm),
    .now_second_i     (drv.ss),
    .entry_index_i    (drv.idx),
    .entry_hour_i     (drv.eh),
    .entry_minute_i   (drv.em),
    .entry_mode_i     (drv.emode),
    .level_value_i    (drv.lvl),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .light_on_i       (light_on),
    .brightness_pct_i (brightness_pct),
    .pwm_level_i      (pwm_level),
    .cause_i          (cause),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count)
  );

  // Result side back-pressure: mostly short bursts, now and then a long one,
  // none at all during quiet stretches
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 20) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_roll < 23) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end else begin
        out_stall  <= 1'b0;
      end
    end
  end

  // Watchdog: give up once neither channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("daily_schedule_light_switch: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'd100;
    if (roll < 20) return 8'd0;
    if (roll < 80) return 8'($urandom_range(1, 100));
    return 8'($urandom_range(101, 255));
  endfunction

  // Fill every field with noise so that unused fields toggle too
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.fn    = 3'($urandom_range(0, 7));
    c.hh    = 5'($urandom_range(0, 31));
    c.mm    = 6'($urandom_range(0, 63));
    c.ss    = 6'($urandom_range(0, 63));
    c.idx   = 7'($urandom_range(0, 127));
    c.eh    = 7'($urandom_range(0, 127));
    c.em    = 7'($urandom_range(0, 127));
    c.emode = 2'($urandom_range(0, 3));
    c.lvl   = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic cmd_t mk_tick(input int h, input int m, input int s);
    cmd_t c;
    c    = noise_cmd();
    c.fn = FUNC_TICK;
    c.hh = 5'(h);
    c.mm = 6'(m);
    c.ss = 6'(s);
    return c;
  endfunction

  function automatic cmd_t mk_write(input int i, input int h, input int m,
                                    input mode_e md, input int lv);
    cmd_t c;
    c       = noise_cmd();
    c.fn    = FUNC_WRITE;
    c.idx   = 7'(i);
    c.eh    = 7'(h);
    c.em    = 7'(m);
    c.emode = md;
    c.lvl   = 8'(lv);
    return c;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] f, input int lv);
    cmd_t c;
    c     = noise_cmd();
    c.fn  = f;
    c.lvl = 8'(lv);
    return c;
  endfunction

  // Tick aimed at a written slot; seconds pick firing, release or second zero
  function automatic cmd_t aimed_tick(input int sec_kind);
    int   k;
    cmd_t c;
    k = $urandom_range(0, NUM_ENTRIES - 1);
    c = mk_tick(int'(aim_hour[k][4:0]), int'(aim_minute[k][5:0]), 0);
    if (sec_kind < 50)      c.ss = 6'($urandom_range(1, 10));
    else if (sec_kind < 85) c.ss = 6'($urandom_range(11, 63));
    else                    c.ss = 6'd0;
    return c;
  endfunction

  // Present one item and hold it until the transfer; call on a rising edge
  task automatic push_item(input cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv      <= c;
    in_valid <= 1'b1;
    if (c.fn == FUNC_WRITE && c.idx < NUM_ENTRIES) begin
      aim_hour[c.idx]   = c.eh;
      aim_minute[c.idx] = c.em;
    end
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic random_traffic();
    int   n;
    int   roll;
    bit   drained;
    cmd_t c;
    n       = 0;
    drained = 1'b0;
    while (n < RANDOM_ITEMS) begin
      quiet <= (n >= 400 && n < 550) || (n >= 1200 && n < 1300);
      if (n >= 800 && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        push_item(aimed_tick($urandom_range(0, 99)));
        n++;
      end else if (roll < 33) begin
        c    = noise_cmd();
        c.fn = FUNC_TICK;
        push_item(c);
        n++;
      end else if (roll < 53) begin
        // Mostly in range and matchable, sometimes out of range or impossible
        c = mk_write(($urandom_range(0, 9) == 0) ? $urandom_range(20, 127)
                                                  : $urandom_range(0, NUM_ENTRIES - 1),
                     ($urandom_range(0, 6) == 0) ? $urandom_range(24, 127)
                                                  : $urandom_range(0, 23),
                     ($urandom_range(0, 6) == 0) ? $urandom_range(60, 127)
                                                  : $urandom_range(0, 59),
                     mode_e'($urandom_range(0, 3)), int'(pick_level()));
        push_item(c);
        n++;
      end else if (roll < 68) begin
        // Release then fire: the usual well-formed tick pair
        push_item(aimed_tick(60));
        push_item(aimed_tick(0));
        n += 2;
      end else begin
        push_item(mk_cmd(3'($urandom_range(FUNC_ON, FUNC_UNUSED)), int'(pick_level())));
        n++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      aim_hour[i]   = 7'd0;
      aim_minute[i] = 7'd0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: nothing can fire
    push_item(mk_tick(0, 0, 5));
    // Write sets the lock; release, second zero, then the first firing second
    push_item(mk_write(0, 7, 30, MODE_ON_EN, 80));
    push_item(mk_tick(7, 30, 5));
    push_item(mk_tick(7, 30, 11));
    push_item(mk_tick(7, 30, 0));
    push_item(mk_tick(7, 30, 1));
    push_item(mk_tick(7, 30, 10));
    // Last slot, off entry with brightness above 100 cleared on firing
    push_item(mk_write(NUM_ENTRIES - 1, 23, 59, MODE_OFF_EN, 200));
    push_item(mk_tick(23, 59, 63));
    push_item(mk_tick(23, 59, 10));
    // Writes beyond the table are ignored
    push_item(mk_write(NUM_ENTRIES, 1, 1, MODE_ON_EN, 10));
    push_item(mk_write(127, 1, 1, MODE_ON_EN, 10));
    // Impossible hour and minute, disabled entries, then the first live match
    push_item(mk_write(1, 24, 0, MODE_ON_EN, 50));
    push_item(mk_write(2, 12, 60, MODE_ON_EN, 50));
    push_item(mk_write(3, 12, 0, MODE_ON_DIS, 40));
    push_item(mk_write(4, 12, 0, MODE_OFF_DIS, 30));
    push_item(mk_write(5, 12, 0, MODE_ON_EN, 100));
    push_item(mk_tick(12, 0, 20));
    push_item(mk_tick(12, 0, 3));
    // Commands, preview and brightness clipping
    push_item(mk_cmd(FUNC_PREVIEW, 37));
    push_item(mk_cmd(FUNC_PREVIEW, 255));
    push_item(mk_cmd(FUNC_SET, 101));
    push_item(mk_cmd(FUNC_SET, 100));
    push_item(mk_cmd(FUNC_TOGGLE, 0));
    push_item(mk_cmd(FUNC_TOGGLE, 0));
    push_item(mk_cmd(FUNC_OFF, 0));
    push_item(mk_cmd(FUNC_ON, 0));
    push_item(mk_cmd(FUNC_UNUSED, 0));
    push_item(mk_tick(31, 63, 63));

    random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("daily_schedule_light_switch: match");
    end else begin
      $display("daily_schedule_light_switch: mismatch");
    end
    $finish;
  end

endmodule
